>>> src/lbdr_pkg.sv
// Shared constants for the letterbox rectangle block: field widths, fixed-point formats, codes.
`default_nettype none
package lbdr_pkg;

	localparam int DIM_IN_W     = 15;   // pixel size fields
	localparam int ASPECT_W     = 16;   // aspect, unsigned Q4.12
	localparam int EDGE_W       = 26;   // edges, unsigned Q18.8
	localparam int SCALE_W      = 32;   // scale, unsigned Q16.16
	localparam int ASP_FRAC     = 12;
	localparam int SCALE_FRAC   = 16;
	localparam int POS_FRAC     = 28;   // internal positions are Q.28
	localparam int Q8_DROP      = POS_FRAC - 8;
	localparam int DIM_BITS_DEF = 14;

	// configuration port
	localparam int PADDR_W      = 3;
	localparam int PDATA_W      = 32;
	localparam int REG_IDX_LSB  = 2;
	localparam int REG_IDX_W    = PADDR_W - REG_IDX_LSB;
	localparam logic [REG_IDX_W-1:0] REG_INT_SCALE = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_ALIGN     = REG_IDX_W'(1);

	// alignment codes; the unused code gives no offset
	localparam int ALIGN_W = 2;
	localparam logic [ALIGN_W-1:0] ALIGN_START  = 2'd0;
	localparam logic [ALIGN_W-1:0] ALIGN_CENTRE = 2'd1;
	localparam logic [ALIGN_W-1:0] ALIGN_END    = 2'd2;

endpackage
`default_nettype wire

>>> src/letterbox_draw_rect.sv
// Top level: pipelined letterbox fit of a source image into a window.
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------------------
//  req     | req_valid / req_ready | win_width, win_height, src_width, src_height, aspect
//  rsp     | rsp_valid / rsp_ready | left_edge, top_edge, right_edge, bottom_edge
//  apb     | psel, penable, pwrite | paddr, pwdata, prdata, pready (always high)
//
// One word enters per cycle when nothing stalls.
// The scale divider has 16 stages, two quotient bits per stage.
// Reset clears the configuration registers and every stage valid bit; data registers keep junk.
// A stage holds while the stage after it is full and stalled; empty stages fill up, so
// req_ready stays high while any stage is free, even with a result waiting on rsp.
// Configuration is sampled live, so change it only while the pipeline is empty.
`default_nettype none
module letterbox_draw_rect
	import lbdr_pkg::*;
#(
	parameter int DIM_BITS = DIM_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// request channel
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire logic [DIM_IN_W-1:0]   win_width,
	input  wire logic [DIM_IN_W-1:0]   win_height,
	input  wire logic [DIM_IN_W-1:0]   src_width,
	input  wire logic [DIM_IN_W-1:0]   src_height,
	input  wire logic [ASPECT_W-1:0]   aspect,
	// response channel
	output logic                       rsp_valid,
	input  wire logic                  rsp_ready,
	output logic [EDGE_W-1:0]          left_edge,
	output logic [EDGE_W-1:0]          top_edge,
	output logic [EDGE_W-1:0]          right_edge,
	output logic [EDGE_W-1:0]          bottom_edge,
	// configuration port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PADDR_W-1:0]    paddr,
	input  wire logic [PDATA_W-1:0]    pwdata,
	output logic [PDATA_W-1:0]         prdata,
	output logic                       pready
);

	// Sizes are clamped to 2^DIM_BITS, but never hold more than the port width.
	localparam int DimW    = (DIM_BITS + 1 > DIM_IN_W) ? DIM_IN_W : DIM_BITS + 1;
	localparam int LimW    = (DIM_BITS + 1 > DIM_IN_W) ? DIM_BITS + 1 : DIM_IN_W;
	localparam int DwW     = ASPECT_W + DimW;          // display width, Q.12
	localparam int NumW    = DimW + POS_FRAC;          // dividend
	localparam int QW      = SCALE_W;
	localparam int BitsPerSt = 2;
	localparam int DivSt   = QW / BitsPerSt;
	localparam int EwW     = DwW + QW;                 // image width on screen, Q.28
	localparam int EhrW    = DimW + QW;                // image height on screen, Q.16
	localparam int EhW     = EhrW + ASP_FRAC;          // same, Q.28
	localparam int GW      = (EwW > EhW) ? EwW : EhW;
	localparam int PosW    = DimW + POS_FRAC;          // offsets never pass the window
	localparam int SumW    = GW + 1;
	localparam int DivFirst = 2;
	localparam int ScSt    = DivFirst + DivSt;
	localparam int GapSt   = ScSt + 1;
	localparam int OutSt   = GapSt + 1;
	localparam int NumSt   = OutSt + 1;

	typedef struct packed {
		logic            wl;     // width-limited fit
		logic            sat;    // quotient does not fit in 32 bits
		logic [DimW-1:0] ww;
		logic [DimW-1:0] wh;
		logic [DimW-1:0] sh;
		logic [DwW-1:0]  dw;
		logic [DwW-1:0]  dvs;    // divisor
	} ctx_t;

	typedef struct packed {
		logic [DwW-1:0] rem;
		logic [QW-1:0]  nq;      // dividend bits still to shift in, quotient shifts in below
	} dstate_t;

	function automatic logic [DimW-1:0] fix_dim(input logic [DIM_IN_W-1:0] v);
		logic [LimW-1:0] x;
		x = LimW'(v);
		if (x == '0) x = LimW'(1);
		if (x > (LimW'(1) << DIM_BITS)) x = LimW'(1) << DIM_BITS;
		return x[DimW-1:0];
	endfunction

	function automatic dstate_t div_step(input dstate_t s, input logic [DwW-1:0] d);
		logic [DwW:0] t;
		dstate_t r;
		t    = {s.rem, s.nq[QW-1]};
		r.nq = {s.nq[QW-2:0], 1'b0};
		if (t >= {1'b0, d}) begin
			r.rem   = DwW'(t - {1'b0, d});
			r.nq[0] = 1'b1;
		end else begin
			r.rem = t[DwW-1:0];
		end
		return r;
	endfunction

	// Truncate Q.28 to Q.8 and saturate to the edge width.
	function automatic logic [EDGE_W-1:0] to_q8(input logic [SumW-1:0] x);
		if (|x[SumW-1:EDGE_W+Q8_DROP]) return '1;
		return x[EDGE_W+Q8_DROP-1:Q8_DROP];
	endfunction

	// ---------------------------------------------------------------- configuration
	logic               integer_scale_q;
	logic [ALIGN_W-1:0] align_mode_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integer_scale_q <= 1'b0;
			align_mode_q    <= ALIGN_CENTRE;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[PADDR_W-1:REG_IDX_LSB])
				REG_INT_SCALE: integer_scale_q <= pwdata[0];
				REG_ALIGN:     align_mode_q    <= pwdata[ALIGN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[PADDR_W-1:REG_IDX_LSB])
			REG_INT_SCALE: prdata = PDATA_W'(integer_scale_q);
			REG_ALIGN:     prdata = PDATA_W'(align_mode_q);
			default:       prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- flow control
	// A stage may load when some stage from it to the end is empty, or the output drains.
	logic [NumSt-1:0] stage_vld_q;
	logic [NumSt:0]   stg_rdy;

	always_comb begin
		for (int k = 0; k < NumSt; k++) begin
			stg_rdy[k] = rsp_ready ||
				!(&(stage_vld_q | ((NumSt'(1) << k) - NumSt'(1))));
		end
		stg_rdy[NumSt] = rsp_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (stg_rdy[0]) stage_vld_q[0] <= req_valid;
			for (int k = 1; k < NumSt; k++) begin
				if (stg_rdy[k]) stage_vld_q[k] <= stage_vld_q[k-1];
			end
		end
	end

	assign req_ready = stg_rdy[0];
	assign rsp_valid = stage_vld_q[NumSt-1];

	// ---------------------------------------------------------------- stage 1: clamp, multiply
	// src_width has no bearing on the result: display width comes from aspect and height.
	logic [DimW-1:0]     ww_s1, wh_s1, sh_s1;
	logic [DwW-1:0]      dw_s1, awh_s1;
	logic [DimW-1:0]     ww_in, wh_in, sh_in;
	logic [ASPECT_W-1:0] asp_in;
	logic                src_unused;

	assign src_unused = ^src_width;
	assign ww_in  = fix_dim(win_width);
	assign wh_in  = fix_dim(win_height);
	assign sh_in  = fix_dim(src_height ^ {DIM_IN_W{src_unused & 1'b0}});
	assign asp_in = (aspect == '0) ? ASPECT_W'(1) : aspect;

	always_ff @(posedge clk) begin
		if (stg_rdy[0]) begin
			ww_s1  <= ww_in;
			wh_s1  <= wh_in;
			sh_s1  <= sh_in;
			dw_s1  <= DwW'(asp_in) * DwW'(sh_in);
			awh_s1 <= DwW'(asp_in) * DwW'(wh_in);
		end
	end

	// ---------------------------------------------------------------- stage 2: pick fit axis
	ctx_t    ctx_s2, ctx_nx2;
	dstate_t ds_s2, ds_nx2;

	always_comb begin
		logic [NumW-1:0] num;
		ctx_nx2.wl  = awh_s1 >= (DwW'(ww_s1) << ASP_FRAC);
		ctx_nx2.ww  = ww_s1;
		ctx_nx2.wh  = wh_s1;
		ctx_nx2.sh  = sh_s1;
		ctx_nx2.dw  = dw_s1;
		ctx_nx2.dvs = ctx_nx2.wl ? dw_s1 : DwW'(sh_s1);
		num         = ctx_nx2.wl ? (NumW'(ww_s1) << POS_FRAC) : (NumW'(wh_s1) << SCALE_FRAC);
		// quotient reaches 2^32 exactly when the bits above it reach the divisor
		ctx_nx2.sat = DwW'(num[NumW-1:QW]) >= ctx_nx2.dvs;
		ds_nx2.rem  = DwW'(num[NumW-1:QW]);
		ds_nx2.nq   = num[QW-1:0];
	end

	always_ff @(posedge clk) begin
		if (stg_rdy[1]) begin
			ctx_s2 <= ctx_nx2;
			ds_s2  <= ds_nx2;
		end
	end

	// ---------------------------------------------------------------- stages 3..18: divider
	// Restoring division, two quotient bits per stage; entry k is stage 3+k.
	ctx_t    div_ctx_s3 [DivSt];
	dstate_t div_st_s3  [DivSt];
	ctx_t    div_ci     [DivSt];
	dstate_t div_si     [DivSt];
	dstate_t div_nx     [DivSt];

	for (genvar k = 0; k < DivSt; k++) begin : g_div
		if (k == 0) begin : g_first
			assign div_ci[k] = ctx_s2;
			assign div_si[k] = ds_s2;
		end else begin : g_next
			assign div_ci[k] = div_ctx_s3[k-1];
			assign div_si[k] = div_st_s3[k-1];
		end

		always_comb begin
			dstate_t s;
			s = div_si[k];
			for (int j = 0; j < BitsPerSt; j++) s = div_step(s, div_ci[k].dvs);
			div_nx[k] = s;
		end

		always_ff @(posedge clk) begin
			if (stg_rdy[DivFirst+k]) begin
				div_ctx_s3[k] <= div_ci[k];
				div_st_s3[k]  <= div_nx[k];
			end
		end
	end

	// ---------------------------------------------------------------- stage 19: scale, extents
	ctx_t             lc;
	logic [QW-1:0]    scale;
	logic [EwW-1:0]   ext_w_s19;
	logic [EhrW-1:0]  ext_hr_s19;
	logic [DimW-1:0]  ww_s19, wh_s19;
	logic             wl_s19;

	assign lc = div_ctx_s3[DivSt-1];

	always_comb begin
		scale = lc.sat ? '1 : div_st_s3[DivSt-1].nq;
		if (integer_scale_q) begin
			// drop the fraction, never below one
			scale = {scale[QW-1:SCALE_FRAC], {SCALE_FRAC{1'b0}}};
			if (scale[QW-1:SCALE_FRAC] == '0) scale = QW'(1) << SCALE_FRAC;
		end
	end

	always_ff @(posedge clk) begin
		if (stg_rdy[ScSt]) begin
			ext_w_s19  <= EwW'(lc.dw) * EwW'(scale);
			ext_hr_s19 <= EhrW'(lc.sh) * EhrW'(scale);
			ww_s19     <= lc.ww;
			wh_s19     <= lc.wh;
			wl_s19     <= lc.wl;
		end
	end

	// ---------------------------------------------------------------- stage 20: offsets
	logic [PosW-1:0] left_s20, top_s20;
	logic [GW-1:0]   ext_w_s20, ext_h_s20;
	logic [PosW-1:0] left_nx, top_nx;
	logic [GW-1:0]   ext_w_nx, ext_h_nx;

	always_comb begin
		logic [GW-1:0] win_w, win_h, ext_w, ext_h, gap_w, gap_h;
		win_w = GW'(ww_s19) << POS_FRAC;
		win_h = GW'(wh_s19) << POS_FRAC;
		ext_w = GW'(ext_w_s19);
		ext_h = GW'(ext_hr_s19) << ASP_FRAC;
		gap_w = (win_w > ext_w) ? win_w - ext_w : '0;
		gap_h = (win_h > ext_h) ? win_h - ext_h : '0;
		left_nx = '0;
		top_nx  = '0;
		if (wl_s19) begin
			if (integer_scale_q) left_nx = PosW'(gap_w >> 1);
			case (align_mode_q)
				ALIGN_CENTRE: top_nx = PosW'(gap_h >> 1);
				ALIGN_END:    top_nx = PosW'(gap_h);
				default:      top_nx = '0;
			endcase
		end else begin
			if (integer_scale_q) top_nx = PosW'(gap_h >> 1);
			case (align_mode_q)
				ALIGN_CENTRE: left_nx = PosW'(gap_w >> 1);
				ALIGN_END:    left_nx = PosW'(gap_w);
				default:      left_nx = '0;
			endcase
		end
		ext_w_nx = ext_w;
		ext_h_nx = ext_h;
	end

	always_ff @(posedge clk) begin
		if (stg_rdy[GapSt]) begin
			left_s20  <= left_nx;
			top_s20   <= top_nx;
			ext_w_s20 <= ext_w_nx;
			ext_h_s20 <= ext_h_nx;
		end
	end

	// ---------------------------------------------------------------- stage 21: edges
	logic [EDGE_W-1:0] left_s21, top_s21, right_s21, bottom_s21;

	always_ff @(posedge clk) begin
		if (stg_rdy[OutSt]) begin
			left_s21   <= to_q8(SumW'(left_s20));
			top_s21    <= to_q8(SumW'(top_s20));
			right_s21  <= to_q8(SumW'(left_s20) + SumW'(ext_w_s20));
			bottom_s21 <= to_q8(SumW'(top_s20) + SumW'(ext_h_s20));
		end
	end

	assign left_edge   = left_s21;
	assign top_edge    = top_s21;
	assign right_edge  = right_s21;
	assign bottom_edge = bottom_s21;

endmodule
`default_nettype wire

>>> src/lbdr_chk.sv
// Port checker for the letterbox rectangle block, bound to the top level.
`default_nettype none
module lbdr_chk
	import lbdr_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_ready,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire logic [EDGE_W-1:0] left_edge,
	input wire logic [EDGE_W-1:0] top_edge,
	input wire logic [EDGE_W-1:0] right_edge,
	input wire logic [EDGE_W-1:0] bottom_edge
);

	// a stalled word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(left_edge) && $stable(top_edge)
			&& $stable(right_edge) && $stable(bottom_edge))
		else $error("stalled response word changed");

	// with the output stage empty some stage is free, so req_ready must be high
	a_req_free: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request stalled with an empty output stage");

	a_width: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> right_edge >= left_edge)
		else $error("right edge left of left edge");

	a_height: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> bottom_edge >= top_edge)
		else $error("bottom edge above top edge");

endmodule

bind letterbox_draw_rect lbdr_chk u_lbdr_chk (.*);
`default_nettype wire
